@@ rtl/huffman_tree_walk_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tree-walk decoder
// Clocked and reset-qualified wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define HTWD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define HTWD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/htwd_pkg.sv @@
// ----------------------------------------------------------------------------
// Tree-walk decoder package
// Field widths, node layout, command codes and sequencer states.
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 9;
    localparam int SYM_W  = 8;

    localparam int NODE_COUNT_DEF = 512;

    // Bits consumed from one word at most; a larger bit count saturates.
    localparam int BITS_PER_ITEM = 8;
    localparam int BIT_LIMIT_I   = (BITS_PER_ITEM < DATA_W) ? BITS_PER_ITEM : DATA_W;
    localparam logic [CNT_W-1:0] BIT_LIMIT = CNT_W'(BIT_LIMIT_I);

    typedef enum logic [CMD_W-1:0] {
        CMD_DECODE  = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } state_t;

endpackage

@@ rtl/htwd_if.sv @@
// ----------------------------------------------------------------------------
// Tree-walk decoder channels
// Valid/ready channels for input words and decoded symbols.
// ----------------------------------------------------------------------------
interface htwd_in_if;
    logic                          valid;
    logic                          ready;
    logic [htwd_pkg::CMD_W-1:0]    command;
    logic [htwd_pkg::DATA_W-1:0]   data_byte;
    logic [htwd_pkg::CNT_W-1:0]    bit_count;
    logic [htwd_pkg::IDX_W-1:0]    node_index;
    logic                          node_is_leaf;
    logic [htwd_pkg::SYM_W-1:0]    node_symbol;
    logic [htwd_pkg::IDX_W-1:0]    node_left;
    logic [htwd_pkg::IDX_W-1:0]    node_right;

    modport source (
        output valid, command, data_byte, bit_count, node_index,
               node_is_leaf, node_symbol, node_left, node_right,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, bit_count, node_index,
               node_is_leaf, node_symbol, node_left, node_right,
        output ready
    );
endinterface

interface htwd_out_if;
    logic                          valid;
    logic                          ready;
    logic [htwd_pkg::SYM_W-1:0]    symbol_out;
    logic                          last_of_run;

    modport source (
        output valid, symbol_out, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, symbol_out, last_of_run,
        output ready
    );
endinterface

@@ rtl/huffman_tree_walk_decoder.sv @@
// Timing: a load or restart word is handled as it is accepted. A decode word
// is accepted, then walks each bit through ST_READ and ST_EVAL and closes in
// ST_FLUSH; a full output can hold it in ST_EVAL or in ST_FLUSH.
// The single node-store read port shapes the walk: each bit needs one or two
// dependent reads, each followed by an evaluate. The block takes one word at a time.
// Reset (rst_n, async, active low) clears the root and walk position to 0.
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder
// Walks a code tree held in a node store, bit by bit with a small
// sequencer sharing one store read port, and emits a symbol per leaf.
// ----------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_assert.svh"

module huffman_tree_walk_decoder #(
    parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    htwd_in_if.sink                     in_ch,
    htwd_out_if.source                  out_ch,
    input  logic                        cfg_we,
    input  logic [htwd_pkg::IDX_W-1:0]  cfg_wdata
);
    import htwd_pkg::*;

    // Store address width, and a width wide enough for both an index field
    // and a store address so that either can be extended to the other.
    localparam int AW = $clog2(NODE_COUNT);
    localparam int PW = (AW > IDX_W) ? AW : IDX_W;

    // Sequencer and walk state.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   root_reg;
    logic [DATA_W-1:0]  shift_reg, shift_next;
    logic [CNT_W-1:0]   bits_left_reg, bits_left_next;
    logic               phase_reg, phase_next;

    // One symbol is held back so that the last symbol of a word can be
    // marked once the word is known to produce no further symbol.
    logic               hold_valid_reg, hold_valid_next;
    logic [SYM_W-1:0]   hold_sym_reg, hold_sym_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   out_sym_reg, out_sym_next;
    logic               out_last_reg, out_last_next;

    // Node store.
    node_t              mem [NODE_COUNT];
    node_t              rd_data_reg;
    logic               rd_oob_reg;
    logic               rd_en;
    logic               wr_en;
    logic [PW-1:0]      rd_addr_wide;
    logic [PW-1:0]      wr_addr_wide;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               rd_oob;
    logic               wr_in_range;

    logic               accept;
    logic               out_free;
    logic               eval_stall;
    logic               more_bits;
    logic               push_en;
    logic               push_last;
    logic [CNT_W-1:0]   cnt_sat;
    node_t              node_cur;
    cmd_t               cmd;

    assign cmd         = cmd_t'(in_ch.command);
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign cnt_sat     = (in_ch.bit_count > BIT_LIMIT) ? BIT_LIMIT : in_ch.bit_count;
    assign more_bits   = (bits_left_reg > CNT_W'(1));

    // An index beyond the store reads as the all-zero node, and a write
    // to such an index is dropped.
    assign rd_addr_wide = PW'(pos_reg);
    assign wr_addr_wide = PW'(in_ch.node_index);
    assign rd_addr      = rd_addr_wide[AW-1:0];
    assign wr_addr      = wr_addr_wide[AW-1:0];
    assign rd_oob       = (32'(pos_reg) >= NODE_COUNT);
    assign wr_in_range  = (32'(in_ch.node_index) < NODE_COUNT);
    assign node_cur     = rd_oob_reg ? '0 : rd_data_reg;

    // A leaf with a symbol already held must push that symbol out first.
    assign eval_stall = node_cur.leaf && hold_valid_reg && !out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_DECODE) && (cnt_sat != '0))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!eval_stall)
                begin
                    if (node_cur.leaf)
                    begin
                        state_next = more_bits ? ST_READ : ST_FLUSH;
                    end
                    else if (!phase_reg)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        // The child just read is internal and is already the
                        // current node for the next bit: no new read needed.
                        state_next = more_bits ? ST_EVAL : ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath controls and register next values.
    always_comb
    begin
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        bits_left_next  = bits_left_reg;
        phase_next      = phase_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        push_en         = 1'b0;
        push_last       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_DECODE:
                        begin
                            shift_next     = in_ch.data_byte;
                            bits_left_next = cnt_sat;
                            phase_next     = 1'b0;
                        end
                        CMD_LOAD:
                        begin
                            wr_en = wr_in_range;
                        end
                        CMD_RESTART:
                        begin
                            pos_next = root_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_EVAL:
            begin
                if (!eval_stall)
                begin
                    if (node_cur.leaf)
                    begin
                        push_en         = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_sym_next   = node_cur.symbol;
                        pos_next        = root_reg;
                        shift_next      = shift_reg << 1;
                        bits_left_next  = bits_left_reg - CNT_W'(1);
                        phase_next      = 1'b0;
                    end
                    else if (!phase_reg)
                    begin
                        pos_next   = shift_reg[DATA_W-1] ? node_cur.right : node_cur.left;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        shift_next     = shift_reg << 1;
                        bits_left_next = bits_left_reg - CNT_W'(1);
                        phase_next     = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (hold_valid_reg && out_free)
                begin
                    push_en         = 1'b1;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
        endcase

        out_valid_next = out_valid_reg;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        if (push_en)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = hold_sym_reg;
            out_last_next  = push_last;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.symbol_out  = out_sym_reg;
    assign out_ch.last_of_run = out_last_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            root_reg       <= '0;
            bits_left_reg  <= '0;
            phase_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            bits_left_reg  <= bits_left_next;
            phase_reg      <= phase_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                root_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        hold_sym_reg <= hold_sym_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    // Node store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= '{leaf:   in_ch.node_is_leaf,
                              symbol: in_ch.node_symbol,
                              left:   in_ch.node_left,
                              right:  in_ch.node_right};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_oob_reg  <= rd_oob;
        end
    end

    // The walk never runs without a bit left to consume.
    `HTWD_ASSERT_IMP(a_bits_present, (state_reg == ST_READ) || (state_reg == ST_EVAL), bits_left_reg != '0, "walk active with no bits left")
    // The bit budget of a word never exceeds the saturation limit.
    `HTWD_ASSERT_IMP(a_bits_limit, 1'b1, bits_left_reg <= BIT_LIMIT, "bit budget above limit")
    // A push never overwrites a symbol that has not been taken.
    `HTWD_ASSERT_IMP(a_no_overwrite, push_en, !out_valid_reg || out_ch.ready, "output overwritten")
    // Leaving the closing step leaves no symbol behind for the next word.
    `HTWD_ASSERT_NXT(a_flush_empty, (state_reg == ST_FLUSH) && (state_next == ST_IDLE), !hold_valid_reg, "held symbol left after word")

endmodule

@@ verif/tb_huffman_tree_walk_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Huffman tree-walk decoder
// Loads code trees into the node store, streams packed code words through the
// block under several pacing modes and root settings, and checks every
// decoded symbol against a tree walk kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder;

    import htwd_pkg::*;

    localparam int NODES = NODE_COUNT_DEF;

    // Command code 3 has no meaning; the block must drop such a word silently.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // The drain allows for the longest decode, one that walks every bit up to the
    // limit through the read and evaluate steps, plus a small margin.
    localparam int DRAIN_CYCLES = 4 * BIT_LIMIT_I + 8;

    // Random words per random phase, and the hard stop for a hung run.
    localparam int  PHASE_WORDS  = 23;
    localparam time RUN_LIMIT_NS = 3_000_000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // One input word, laid out in the order of the channel fields.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data_byte;
        logic [CNT_W-1:0]  bit_count;
        logic [IDX_W-1:0]  node_index;
        logic              node_is_leaf;
        logic [SYM_W-1:0]  node_symbol;
        logic [IDX_W-1:0]  node_left;
        logic [IDX_W-1:0]  node_right;
    } code_word_t;

    // One decoded symbol as it should appear on the output channel.
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } decoded_sym_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_wdata;

    htwd_in_if  code_ch ();
    htwd_out_if sym_ch ();

    huffman_tree_walk_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (code_ch),
        .out_ch    (sym_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Shared state between the stimulus plan, the driver and the monitor.
    // ------------------------------------------------------------------------
    code_word_t   queued_words [$];     // words waiting to be driven
    decoded_sym_t pending_symbols [$];  // symbols predicted but not yet seen
    idle_mode_t   idle_mode;

    int words_queued;
    int words_accepted;
    int decode_words;
    int symbols_checked;
    int mismatches;
    int roots_tried;

    // Decoder state as the testbench tracks it at the moment each word is
    // accepted: the node store, the root register and the walk position.
    node_t            tree_mem [NODES];
    logic [IDX_W-1:0] root_reg;
    logic [IDX_W-1:0] walk_pos;

    // Bookkeeping used while planning stimulus. The node store is undefined
    // until written, so the plan keeps track of which entries will have been
    // written and only ever points internal nodes at those.
    bit               planned [NODES];
    logic [IDX_W-1:0] planned_nodes [$];
    logic [IDX_W-1:0] planned_root;

    // ------------------------------------------------------------------------
    // Clock: 10 ns period.
    // ------------------------------------------------------------------------
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int send_gap_pct(input idle_mode_t mode);
        return (mode == IDLE_SEND) ? 45 : (mode == IDLE_BOTH) ? 6 : 0;
    endfunction

    function automatic int recv_stall_pct(input idle_mode_t mode);
        return (mode == IDLE_RECV) ? 45 : (mode == IDLE_BOTH) ? 6 : 0;
    endfunction

    // Only the first ten mismatches are printed; the rest are only counted.
    task automatic note_mismatch(input string what,
                                 input logic [SYM_W-1:0] exp_sym, input logic exp_last,
                                 input logic [SYM_W-1:0] got_sym, input logic got_last);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t ns: %s: expected symbol %02h last %0b, got symbol %02h last %0b",
                     $time, what, exp_sym, exp_last, got_sym, got_last);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tree walk for one accepted word. Loads write a node, restarts return the
    // walk to the root, and decode words consume their leading bits most
    // significant first. A node that is already a leaf when a bit arrives
    // emits its symbol without moving, which is how a root leaf produces one
    // symbol per bit. Otherwise the walk steps to a child, and if that child
    // is a leaf its symbol is emitted. Either way an emit sends the walk back
    // to the root. The final symbol of a word carries the last flag.
    // ------------------------------------------------------------------------
    function automatic void walk_code_word(input code_word_t w);
        decoded_sym_t     run [$];
        node_t            cur;
        logic [CNT_W-1:0] nbits;
        case (w.command)
            CMD_LOAD:
            begin
                tree_mem[w.node_index] = {w.node_is_leaf, w.node_symbol,
                                          w.node_left, w.node_right};
            end
            CMD_RESTART:
            begin
                walk_pos = root_reg;
            end
            CMD_DECODE:
            begin
                // A bit count above the per-word limit saturates.
                nbits = (w.bit_count > BIT_LIMIT) ? BIT_LIMIT : w.bit_count;
                for (int i = 0; i < nbits; i++)
                begin
                    cur = tree_mem[walk_pos];
                    if (!cur.leaf)
                    begin
                        walk_pos = w.data_byte[DATA_W - 1 - i] ? cur.right : cur.left;
                        cur = tree_mem[walk_pos];
                    end
                    if (cur.leaf)
                    begin
                        run.push_back('{symbol: cur.symbol, last: 1'b0});
                        walk_pos = root_reg;
                    end
                end
                if (run.size() > 0)
                begin
                    run[run.size() - 1].last = 1'b1;
                end
                foreach (run[j])
                begin
                    pending_symbols.push_back(run[j]);
                end
            end
            default:
            begin
                // The unused command code leaves all state alone.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A word stays on the channel until it is taken; once taken, or
    // when the channel is empty, the next queued word goes out unless the
    // current pacing mode inserts an idle cycle. The tree walk runs on the
    // word at the edge that accepts it, and a root register write is tracked
    // at the edge that performs it.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_ch.valid        <= 1'b0;
            code_ch.command      <= CMD_DECODE;
            code_ch.data_byte    <= '0;
            code_ch.bit_count    <= '0;
            code_ch.node_index   <= '0;
            code_ch.node_is_leaf <= 1'b0;
            code_ch.node_symbol  <= '0;
            code_ch.node_left    <= '0;
            code_ch.node_right   <= '0;
            root_reg = '0;
            walk_pos = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                root_reg = cfg_wdata;
            end
            if (code_ch.valid && code_ch.ready)
            begin
                walk_code_word({code_ch.command, code_ch.data_byte, code_ch.bit_count,
                                code_ch.node_index, code_ch.node_is_leaf,
                                code_ch.node_symbol, code_ch.node_left,
                                code_ch.node_right});
                if (code_ch.command == CMD_DECODE)
                begin
                    decode_words++;
                end
                words_accepted++;
            end
            if (!code_ch.valid || code_ch.ready)
            begin
                if (queued_words.size() > 0 && $urandom_range(99) >= send_gap_pct(idle_mode))
                begin
                    code_ch.valid        <= 1'b1;
                    code_ch.command      <= queued_words[0].command;
                    code_ch.data_byte    <= queued_words[0].data_byte;
                    code_ch.bit_count    <= queued_words[0].bit_count;
                    code_ch.node_index   <= queued_words[0].node_index;
                    code_ch.node_is_leaf <= queued_words[0].node_is_leaf;
                    code_ch.node_symbol  <= queued_words[0].node_symbol;
                    code_ch.node_left    <= queued_words[0].node_left;
                    code_ch.node_right   <= queued_words[0].node_right;
                    void'(queued_words.pop_front());
                end
                else
                begin
                    code_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every symbol taken from the output channel is matched against
    // the oldest prediction; ready is redrawn each cycle from the pacing mode.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_ch.ready <= 1'b0;
        end
        else
        begin
            if (sym_ch.valid && sym_ch.ready)
            begin
                if (pending_symbols.size() == 0)
                begin
                    note_mismatch("symbol with no decode pending", '0, 1'b0,
                                  sym_ch.symbol_out, sym_ch.last_of_run);
                end
                else
                begin
                    if (sym_ch.symbol_out !== pending_symbols[0].symbol
                        || sym_ch.last_of_run !== pending_symbols[0].last)
                    begin
                        note_mismatch("wrong symbol_out or last_of_run",
                                      pending_symbols[0].symbol, pending_symbols[0].last,
                                      sym_ch.symbol_out, sym_ch.last_of_run);
                    end
                    void'(pending_symbols.pop_front());
                end
                symbols_checked++;
            end
            sym_ch.ready <= ($urandom_range(99) >= recv_stall_pct(idle_mode));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Every field random, so that the fields a command ignores still toggle.
    function automatic code_word_t random_word(input logic [CMD_W-1:0] cmd);
        code_word_t w;
        w.command      = cmd;
        w.data_byte    = DATA_W'($urandom_range(255));
        w.bit_count    = CNT_W'($urandom_range(15));
        w.node_index   = IDX_W'($urandom_range(NODES - 1));
        w.node_is_leaf = 1'($urandom_range(1));
        w.node_symbol  = SYM_W'($urandom_range(255));
        w.node_left    = IDX_W'($urandom_range(NODES - 1));
        w.node_right   = IDX_W'($urandom_range(NODES - 1));
        return w;
    endfunction

    task automatic push_word(input code_word_t w);
        if (w.command == CMD_LOAD && !planned[w.node_index])
        begin
            planned[w.node_index] = 1'b1;
            planned_nodes.push_back(w.node_index);
        end
        queued_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_node(input logic [IDX_W-1:0] idx, input logic leaf,
                             input logic [SYM_W-1:0] sym,
                             input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right);
        code_word_t w;
        w = random_word(CMD_LOAD);
        w.node_index   = idx;
        w.node_is_leaf = leaf;
        w.node_symbol  = sym;
        w.node_left    = left;
        w.node_right   = right;
        push_word(w);
    endtask

    task automatic push_decode(input logic [DATA_W-1:0] bits, input logic [CNT_W-1:0] count);
        code_word_t w;
        w = random_word(CMD_DECODE);
        w.data_byte = bits;
        w.bit_count = count;
        push_word(w);
    endtask

    // Builds a random full code tree whose root sits at top. Leaves are
    // written first and random pairs of subtrees are joined under new internal
    // nodes, so every internal node is written after both of its children.
    // A single leaf makes the root itself a leaf.
    task automatic queue_code_tree(input logic [IDX_W-1:0] top, input int leaves);
        bit               taken [NODES];
        logic [IDX_W-1:0] subtrees [$];
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        int               k;
        taken[top] = 1'b1;
        for (int n = 0; n < leaves; n++)
        begin
            idx = top;
            if (leaves > 1)
            begin
                do
                    idx = IDX_W'($urandom_range(NODES - 1));
                while (taken[idx]);
                taken[idx] = 1'b1;
            end
            push_node(idx, 1'b1, SYM_W'($urandom_range(255)),
                      IDX_W'($urandom_range(NODES - 1)), IDX_W'($urandom_range(NODES - 1)));
            subtrees.push_back(idx);
        end
        while (subtrees.size() > 1)
        begin
            k = $urandom_range(subtrees.size() - 1);
            a = subtrees[k];
            subtrees.delete(k);
            k = $urandom_range(subtrees.size() - 1);
            b = subtrees[k];
            subtrees.delete(k);
            idx = top;
            if (subtrees.size() > 0)
            begin
                do
                    idx = IDX_W'($urandom_range(NODES - 1));
                while (taken[idx]);
                taken[idx] = 1'b1;
            end
            push_node(idx, 1'b0, SYM_W'($urandom_range(255)), a, b);
            subtrees.push_back(idx);
        end
    endtask

    // Waits until every queued word has been taken and every predicted symbol
    // has arrived, then lets a decode that emits nothing run to its end.
    task automatic wait_quiet();
        while (words_accepted != words_queued || pending_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_root(input logic [IDX_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        planned_root = value;
        roots_tried++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, a directed part on a fixed tree, then four random
    // phases, one per pacing mode, each with its own root setting.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [IDX_W-1:0]  root_plan [4];
        code_word_t        w;
        logic [CNT_W-1:0]  count;
        int                pick;
        int                counted;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        idle_mode            = IDLE_NONE;
        words_queued         = 0;
        roots_tried          = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The fixed tree rooted at node 0 has the codes
        // 0 -> 00, 10 -> FF, 110 -> 5A and 111 -> A5. Nodes are written
        // bottom-up, and node 0 is written before the first decode because
        // the walk starts there out of reset.
        write_root('0);
        push_node(9'd300, 1'b1, 8'h00, 9'd511, 9'd0);
        push_node(9'd100, 1'b1, 8'hFF, 9'd0, 9'd511);
        push_node(9'd44,  1'b1, 8'h5A, 9'd170, 9'd341);
        push_node(9'd45,  1'b1, 8'hA5, 9'd341, 9'd170);
        push_node(9'd256, 1'b0, 8'h81, 9'd44, 9'd45);
        push_node(9'd7,   1'b0, 8'h7E, 9'd100, 9'd256);
        push_node(9'd0,   1'b0, 8'h00, 9'd300, 9'd7);
        push_decode(8'h00, 4'd0);       // zero bit count emits nothing
        push_decode(8'h00, 4'd8);       // eight short codes in one word
        push_decode(8'hFF, 4'd8);       // ends with the walk mid-tree
        push_decode(8'hFF, 4'd15);      // oversized count saturates
        push_word(random_word(CMD_UNUSED));
        push_word(random_word(CMD_RESTART));
        push_decode(8'hB5, 4'd9);
        push_decode(8'h80, 4'd1);
        push_word(random_word(CMD_RESTART));
        push_decode(8'hC0, 4'd2);       // leaves the walk parked on node 256

        // Moving the root while the walk is parked: the first bit still
        // follows the old tree, then every return lands on a root that is a
        // leaf, which emits once per bit for the remaining seven bits.
        wait_quiet();
        write_root('1);
        push_node('1, 1'b1, 8'h3C, 9'd0, 9'd511);
        push_decode(8'h80, 4'd8);
        push_word(random_word(CMD_RESTART));
        push_decode(8'h00, 4'd3);

        // Random phases. Most words are decodes of random bytes over well
        // formed trees; the rest are restarts, stray node writes, words with
        // the unused command and fresh trees built on the current root.
        root_plan = '{IDX_W'($urandom_range(1, NODES - 2)), '0, '1,
                      IDX_W'($urandom_range(NODES - 1))};
        for (int p = 0; p < 4; p++)
        begin
            wait_quiet();
            idle_mode = idle_mode_t'(p);
            write_root(root_plan[p]);
            queue_code_tree(planned_root, $urandom_range(2, 12));
            counted = 0;
            while (counted < PHASE_WORDS)
            begin
                pick = $urandom_range(99);
                if (pick < 66)
                begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        count = '0;
                    else if (pick < 18)
                        count = CNT_W'($urandom_range(9, 15));
                    else if (pick < 55)
                        count = BIT_LIMIT;
                    else
                        count = CNT_W'($urandom_range(1, 7));
                    push_decode(DATA_W'($urandom_range(255)), count);
                end
                else if (pick < 74)
                begin
                    push_word(random_word(CMD_RESTART));
                end
                else if (pick < 84)
                begin
                    // A stray node write may land anywhere, but an internal
                    // node only ever points at entries already written.
                    w = random_word(CMD_LOAD);
                    if (!w.node_is_leaf)
                    begin
                        w.node_left  = planned_nodes[$urandom_range(planned_nodes.size() - 1)];
                        w.node_right = planned_nodes[$urandom_range(planned_nodes.size() - 1)];
                    end
                    push_word(w);
                end
                else if (pick < 90)
                begin
                    // Ignored by the block, so it does not count as work.
                    push_word(random_word(CMD_UNUSED));
                    counted--;
                end
                else
                begin
                    queue_code_tree(planned_root, $urandom_range(1, 6));
                end
                counted++;
            end
        end

        wait_quiet();

        $display("Summary: %0d words taken, %0d of them decodes, %0d symbols checked, %0d mismatches.",
                 words_accepted, decode_words, symbols_checked, mismatches);
        $display("The root register took %0d settings, both ends of its range among them.",
                 roots_tried);
        if (mismatches == 0)
        begin
            $display("huffman_tree_walk_decoder verification clean");
        end
        else
        begin
            $display("huffman_tree_walk_decoder verification failed");
        end
        $finish;
    end

    // A hung handshake or a symbol that never arrives ends here.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("huffman_tree_walk_decoder verification failed");
        $finish;
    end

endmodule
